>>> rtl/ofq_pkg.sv
// Shared types and constants for the overwrite-oldest frame queue.
// Used by ofq_ctrl, ofq_obuf and overwrite_oldest_frame_queue; depends on nothing.

package ofq_pkg;

  localparam int WORD_W    = 64;
  localparam int LEN_W     = 16;
  localparam int QUEUED_W  = 4;
  localparam int DROPPED_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_UNDEF = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WORD_W-1:0]    pop_word;
    logic                 pop_last;
    logic [QUEUED_W-1:0]  queued;
    logic [DROPPED_W-1:0] dropped;
  } beat_t;

endpackage

>>> rtl/ofq_mem.sv
// Frame store: one write port and one read port with a registered read.
// Depends on nothing; instantiated by overwrite_oldest_frame_queue.

module ofq_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] ram_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ram_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/ofq_obuf.sv
// Two-entry result buffer that decouples the sequencer from the result channel.
// Depends on ofq_pkg.

module ofq_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ofq_pkg::beat_t wr_beat,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ofq_pkg::beat_t rd_beat
);

  ofq_pkg::beat_t entry_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_beat  = entry_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= wr_beat;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/ofq_ctrl.sv
// Queue sequencer: slot pointers, frame count, drop count and pop streaming.
// Depends on ofq_pkg; drives ofq_mem and ofq_obuf.

module ofq_ctrl #(
  parameter int QUEUE_DEPTH = 8,
  parameter int FRAME_BYTES = 256,
  parameter int ADDR_W      = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [ofq_pkg::WORD_W-1:0]  in_push_word,
  input  logic                        in_push_last,
  input  logic [ofq_pkg::LEN_W-1:0]   in_frame_length,
  output logic                        ob_valid,
  input  logic                        ob_ready,
  output ofq_pkg::beat_t              ob_beat,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [ofq_pkg::WORD_W-1:0]  wr_data,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [ofq_pkg::WORD_W-1:0]  rd_data
);

  localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
  localparam int SLOT_W      = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int HELD_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W       = (FRAME_WORDS > 2) ? $clog2(FRAME_WORDS) : 1;
  localparam int CNT_W       = $clog2(FRAME_WORDS + 1);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t                       state_r, state_nxt;
  logic [SLOT_W-1:0]            rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0]            wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0]            pop_slot_r, pop_slot_nxt;
  logic [HELD_W-1:0]            held_r, held_nxt;
  logic [ofq_pkg::DROPPED_W-1:0] drop_r, drop_nxt;
  logic [POS_W-1:0]             push_pos_r, push_pos_nxt;
  logic [CNT_W-1:0]             rd_pos_r, rd_pos_nxt;
  logic                         dv_r, dv_nxt;
  logic                         dlast_r, dlast_nxt;

  logic                         accept;
  logic                         len_ok;
  logic                         fire;
  logic                         issue;
  logic [HELD_W-1:0]            held_a;
  logic [CNT_W-1:0]             pos_inc;
  logic [1:0]                   status;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign in_ready = (state_r == S_IDLE) && ob_ready;
  assign accept   = in_valid && in_ready;
  assign len_ok   = (in_frame_length == ofq_pkg::LEN_W'(FRAME_BYTES));
  assign pos_inc  = CNT_W'(push_pos_r) + CNT_W'(1);
  assign fire     = (state_r == S_POP) && dv_r && ob_ready;
  assign issue    = (state_r == S_POP) && (!dv_r || fire) &&
                    (rd_pos_r != CNT_W'(FRAME_WORDS));

  assign wr_data  = in_push_word;
  assign wr_addr  = ADDR_W'(wr_slot_r) * ADDR_W'(FRAME_WORDS) + ADDR_W'(push_pos_r);
  assign rd_en    = issue;
  assign rd_addr  = ADDR_W'(pop_slot_r) * ADDR_W'(FRAME_WORDS) + ADDR_W'(rd_pos_r);

  always_comb begin
    state_nxt    = state_r;
    rd_slot_nxt  = rd_slot_r;
    wr_slot_nxt  = wr_slot_r;
    pop_slot_nxt = pop_slot_r;
    held_nxt     = held_r;
    drop_nxt     = drop_r;
    push_pos_nxt = push_pos_r;
    rd_pos_nxt   = rd_pos_r;
    dv_nxt       = dv_r;
    dlast_nxt    = dlast_r;
    held_a       = held_r;
    status       = ofq_pkg::ST_OK;
    wr_en        = 1'b0;
    ob_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ob_valid = 1'b1;
          case (in_op)
            ofq_pkg::OP_PUSH: begin
              if (push_pos_r == '0 && !len_ok) begin
                status = ofq_pkg::ST_BAD_ARG;
              end else begin
                if (push_pos_r == '0 && held_r >= HELD_W'(QUEUE_DEPTH)) begin
                  rd_slot_nxt = slot_inc(rd_slot_r);
                  held_a      = HELD_W'(QUEUE_DEPTH - 1);
                  if (drop_r != '1) begin
                    drop_nxt = drop_r + ofq_pkg::DROPPED_W'(1);
                  end
                end
                held_nxt = held_a;
                if (in_push_last && pos_inc < CNT_W'(FRAME_WORDS)) begin
                  push_pos_nxt = '0;
                  status       = ofq_pkg::ST_BAD_ARG;
                end else begin
                  wr_en = 1'b1;
                  if (pos_inc >= CNT_W'(FRAME_WORDS)) begin
                    push_pos_nxt = '0;
                    wr_slot_nxt  = slot_inc(wr_slot_r);
                    held_nxt     = held_a + HELD_W'(1);
                  end else begin
                    push_pos_nxt = POS_W'(pos_inc);
                  end
                end
              end
            end
            ofq_pkg::OP_POP: begin
              if (!len_ok) begin
                status = ofq_pkg::ST_BAD_ARG;
              end else if (held_r == '0) begin
                status = ofq_pkg::ST_EMPTY;
              end else begin
                ob_valid     = 1'b0;
                pop_slot_nxt = rd_slot_r;
                rd_slot_nxt  = slot_inc(rd_slot_r);
                held_nxt     = held_r - HELD_W'(1);
                rd_pos_nxt   = '0;
                dv_nxt       = 1'b0;
                state_nxt    = S_POP;
              end
            end
            ofq_pkg::OP_CLEAR: begin
              rd_slot_nxt  = '0;
              wr_slot_nxt  = '0;
              held_nxt     = '0;
              push_pos_nxt = '0;
            end
            default: begin
              status = ofq_pkg::ST_BAD_ARG;
            end
          endcase
        end
      end
      S_POP: begin
        ob_valid = dv_r;
        if (issue) begin
          rd_pos_nxt = rd_pos_r + CNT_W'(1);
          dv_nxt     = 1'b1;
          dlast_nxt  = (rd_pos_r == CNT_W'(FRAME_WORDS - 1));
        end else if (fire) begin
          dv_nxt = 1'b0;
        end
        if (fire && dlast_r) begin
          state_nxt = S_IDLE;
          dv_nxt    = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ob_beat.status   = status;
    ob_beat.pop_word = '0;
    ob_beat.pop_last = 1'b1;
    ob_beat.queued   = ofq_pkg::QUEUED_W'(held_nxt);
    ob_beat.dropped  = drop_nxt;
    if (state_r == S_POP) begin
      ob_beat.status   = ofq_pkg::ST_OK;
      ob_beat.pop_word = rd_data;
      ob_beat.pop_last = dlast_r;
      ob_beat.queued   = ofq_pkg::QUEUED_W'(held_r);
      ob_beat.dropped  = drop_r;
    end
  end

  always_ff @(posedge clk) begin
    pop_slot_r <= pop_slot_nxt;
    dlast_r    <= dlast_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_slot_r  <= '0;
      wr_slot_r  <= '0;
      held_r     <= '0;
      drop_r     <= '0;
      push_pos_r <= '0;
      rd_pos_r   <= '0;
      dv_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_slot_r  <= rd_slot_nxt;
      wr_slot_r  <= wr_slot_nxt;
      held_r     <= held_nxt;
      drop_r     <= drop_nxt;
      push_pos_r <= push_pos_nxt;
      rd_pos_r   <= rd_pos_nxt;
      dv_r       <= dv_nxt;
    end
  end

endmodule

>>> rtl/overwrite_oldest_frame_queue.sv
// Top level of the overwrite-oldest frame queue.
// Depends on ofq_pkg, ofq_mem, ofq_obuf and ofq_ctrl.
//
//   channel   direction   beat
//   in_*      in          op, push word, push last marker, stated frame length
//   out_*     out         status, pop word, pop last marker, queued, dropped
//
// A push, clear, undefined op, rejected pop or empty pop gives one beat.
// A good pop gives one beat per frame word, one memory read a cycle while the result
// buffer has room, limited by the single read port of the frame store and its registered read.
// A two-entry result buffer lets input beats be taken while results wait.
// Reset clears pointers, counts and handshake state; frame contents are not cleared.
// Stalls on the result side hold the pop stream and, once the buffer fills, the input.

module overwrite_oldest_frame_queue #(
  parameter int QUEUE_DEPTH = 8,
  parameter int FRAME_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [ofq_pkg::WORD_W-1:0]     in_push_word,
  input  logic                           in_push_last,
  input  logic [ofq_pkg::LEN_W-1:0]      in_frame_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [ofq_pkg::WORD_W-1:0]     out_pop_word,
  output logic                           out_pop_last,
  output logic [ofq_pkg::QUEUED_W-1:0]   out_queued,
  output logic [ofq_pkg::DROPPED_W-1:0]  out_dropped
);

  localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
  localparam int MEM_DEPTH   = QUEUE_DEPTH * FRAME_WORDS;
  localparam int ADDR_W      = (MEM_DEPTH > 2) ? $clog2(MEM_DEPTH) : 1;

  logic                         ob_valid;
  logic                         ob_ready;
  ofq_pkg::beat_t               ob_beat;
  ofq_pkg::beat_t               res_beat;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [ofq_pkg::WORD_W-1:0]   wr_data;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [ofq_pkg::WORD_W-1:0]   rd_data;

  ofq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_push_word    (in_push_word),
    .in_push_last    (in_push_last),
    .in_frame_length (in_frame_length),
    .ob_valid        (ob_valid),
    .ob_ready        (ob_ready),
    .ob_beat         (ob_beat),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  ofq_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ofq_pkg::WORD_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ofq_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (ob_valid),
    .wr_ready (ob_ready),
    .wr_beat  (ob_beat),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_beat  (res_beat)
  );

  assign out_status   = res_beat.status;
  assign out_pop_word = res_beat.pop_word;
  assign out_pop_last = res_beat.pop_last;
  assign out_queued   = res_beat.queued;
  assign out_dropped  = res_beat.dropped;

endmodule

>>> test/tb.sv
// Self-checking testbench for overwrite_oldest_frame_queue: drives frame pushes, pops,
// clears and malformed requests, and checks every result beat against a built-in predictor.
// Depends on ofq_pkg and the overwrite_oldest_frame_queue RTL.
`timescale 1ns / 100ps

module tb;

  localparam int QUEUE_DEPTH = 8;
  localparam int FRAME_BYTES = 256;
  localparam int FRAME_WORDS = (FRAME_BYTES + 7) / 8;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int ITEM_TARGET = 360;
  localparam int WORD_W      = ofq_pkg::WORD_W;
  localparam int LEN_W       = ofq_pkg::LEN_W;
  localparam int QUEUED_W    = ofq_pkg::QUEUED_W;
  localparam int DROPPED_W   = ofq_pkg::DROPPED_W;
  localparam logic [LEN_W-1:0] GOOD_LEN = LEN_W'(FRAME_BYTES);

  typedef enum {FR_CLEAN, FR_NO_LAST, FR_EARLY_LAST, FR_WITH_POP, FR_WITH_CLEAR} frame_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  ofq_pkg::op_t         in_op;
  logic [WORD_W-1:0]    in_push_word;
  logic                 in_push_last;
  logic [LEN_W-1:0]     in_frame_length;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [WORD_W-1:0]    out_pop_word;
  logic                 out_pop_last;
  logic [QUEUED_W-1:0]  out_queued;
  logic [DROPPED_W-1:0] out_dropped;

  // Predicted queue state.
  logic [WORD_W-1:0]    frame_mem [QUEUE_DEPTH*FRAME_WORDS];
  logic [SLOT_W-1:0]    q_rd = '0;
  logic [SLOT_W-1:0]    q_wr = '0;
  logic [QUEUED_W-1:0]  q_count = '0;
  logic [DROPPED_W-1:0] q_drops = '0;
  int                   push_idx = 0;

  ofq_pkg::beat_t pending_beats[$];
  int    mismatches = 0;
  int    items_sent = 0;
  int    burst_left = 0;
  bit    holdoff_req = 0;

  overwrite_oldest_frame_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FRAME_BYTES(FRAME_BYTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_push_word(in_push_word),
    .in_push_last(in_push_last),
    .in_frame_length(in_frame_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_pop_word(out_pop_word),
    .out_pop_last(out_pop_last),
    .out_queued(out_queued),
    .out_dropped(out_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic ofq_pkg::beat_t result_beat(ofq_pkg::status_t st, logic [WORD_W-1:0] w,
                                                 logic l);
    ofq_pkg::beat_t b;
    b.status   = st;
    b.pop_word = w;
    b.pop_last = l;
    b.queued   = q_count;
    b.dropped  = q_drops;
    return b;
  endfunction

  task automatic predict_queue_beats(ofq_pkg::op_t op, logic [WORD_W-1:0] word, logic last,
                                     logic [LEN_W-1:0] len);
    int base;
    case (op)
      ofq_pkg::OP_PUSH: begin
        if (push_idx == 0 && len != GOOD_LEN) begin
          pending_beats.push_back(result_beat(ofq_pkg::ST_BAD_ARG, '0, 1'b1));
        end else begin
          if (push_idx == 0 && q_count >= QUEUE_DEPTH) begin
            q_rd = SLOT_W'((q_rd + 1) % QUEUE_DEPTH);
            q_count = QUEUED_W'(QUEUE_DEPTH - 1);
            if (q_drops != '1) q_drops++;
          end
          if (last && push_idx + 1 < FRAME_WORDS) begin
            push_idx = 0;
            pending_beats.push_back(result_beat(ofq_pkg::ST_BAD_ARG, '0, 1'b1));
          end else begin
            frame_mem[int'(q_wr) * FRAME_WORDS + push_idx] = word;
            push_idx++;
            if (push_idx >= FRAME_WORDS) begin
              push_idx = 0;
              q_wr = SLOT_W'((q_wr + 1) % QUEUE_DEPTH);
              q_count++;
            end
            pending_beats.push_back(result_beat(ofq_pkg::ST_OK, '0, 1'b1));
          end
        end
      end
      ofq_pkg::OP_POP: begin
        if (len != GOOD_LEN) begin
          pending_beats.push_back(result_beat(ofq_pkg::ST_BAD_ARG, '0, 1'b1));
        end else if (q_count == 0) begin
          pending_beats.push_back(result_beat(ofq_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          base = int'(q_rd) * FRAME_WORDS;
          q_rd = SLOT_W'((q_rd + 1) % QUEUE_DEPTH);
          q_count--;
          for (int k = 0; k < FRAME_WORDS; k++) begin
            pending_beats.push_back(result_beat(ofq_pkg::ST_OK, frame_mem[base + k],
                                                k == FRAME_WORDS - 1));
          end
        end
      end
      ofq_pkg::OP_CLEAR: begin
        q_rd = '0;
        q_wr = '0;
        q_count = '0;
        push_idx = 0;
        pending_beats.push_back(result_beat(ofq_pkg::ST_OK, '0, 1'b1));
      end
      default: begin
        pending_beats.push_back(result_beat(ofq_pkg::ST_BAD_ARG, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    ofq_pkg::beat_t exp_b;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_queue_beats(in_op, in_push_word, in_push_last, in_frame_length);
      end
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got status %0d word %0h",
                   $time, out_status, out_pop_word);
        end else begin
          exp_b = pending_beats.pop_front();
          check_field("status", WORD_W'(exp_b.status), WORD_W'(out_status));
          check_field("pop_word", exp_b.pop_word, out_pop_word);
          check_field("pop_last", WORD_W'(exp_b.pop_last), WORD_W'(out_pop_last));
          check_field("queued", WORD_W'(exp_b.queued), WORD_W'(out_queued));
          check_field("dropped", WORD_W'(exp_b.dropped), WORD_W'(out_dropped));
        end
      end
    end
  end

  // The receiver stalls in phases of its own, with one long hold-off on request.
  initial begin : receiver
    int cyc;
    cyc = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        case ((cyc / 97) % 4)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 3) != 0);
          2: out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = (cyc % 5 != 2);
        endcase
      end
    end
  end

  function automatic logic [WORD_W-1:0] frame_word();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] bad_length();
    logic [LEN_W-1:0] l;
    l = ($urandom_range(0, 4) == 0) ? '0 : LEN_W'($urandom);
    if (l == GOOD_LEN) l = '1;
    return l;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_beat(ofq_pkg::op_t op, logic [WORD_W-1:0] word, logic last,
                           logic [LEN_W-1:0] len);
    int gap;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid = 1'b1;
    in_op = op;
    in_push_word = word;
    in_push_last = last;
    in_frame_length = len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (FRAME_WORDS + 8) @(negedge clk);
  endtask

  task automatic push_frame(frame_kind_t kind);
    int cut;
    logic last;
    logic [LEN_W-1:0] len;
    cut = $urandom_range(0, FRAME_WORDS - 2);
    for (int w = 0; w < FRAME_WORDS; w++) begin
      if (kind == FR_WITH_POP && w == cut) begin
        send_beat(ofq_pkg::OP_POP, frame_word(), rand_bit(), GOOD_LEN);
      end
      if (kind == FR_WITH_CLEAR && w == cut) begin
        send_beat(ofq_pkg::OP_CLEAR, frame_word(), rand_bit(), LEN_W'($urandom));
        break;
      end
      len = (w == 0 || $urandom_range(0, 3) == 0) ? GOOD_LEN : LEN_W'($urandom);
      last = (w == FRAME_WORDS - 1) ? (kind != FR_NO_LAST) : (kind == FR_EARLY_LAST && w == cut);
      send_beat(ofq_pkg::OP_PUSH, frame_word(), last, len);
      if (last && w < FRAME_WORDS - 1) break;
    end
  endtask

  task automatic test_rejects_on_empty();
    send_beat(ofq_pkg::OP_POP, '0, 1'b0, GOOD_LEN);
    send_beat(ofq_pkg::OP_POP, '1, 1'b1, '0);
    send_beat(ofq_pkg::OP_POP, '0, 1'b0, '1);
    send_beat(ofq_pkg::OP_PUSH, '1, 1'b0, '0);
    send_beat(ofq_pkg::OP_PUSH, '0, 1'b0, LEN_W'(FRAME_BYTES - 1));
    send_beat(ofq_pkg::OP_PUSH, '1, 1'b1, '1);
    send_beat(ofq_pkg::OP_UNDEF, '1, 1'b1, GOOD_LEN);
    send_beat(ofq_pkg::OP_UNDEF, '0, 1'b0, '0);
    send_beat(ofq_pkg::OP_CLEAR, '1, 1'b1, '1);
    send_beat(ofq_pkg::OP_PUSH, '1, 1'b1, GOOD_LEN);
    send_beat(ofq_pkg::OP_PUSH, '0, 1'b0, GOOD_LEN);
    send_beat(ofq_pkg::OP_PUSH, '1, 1'b1, '0);
    send_beat(ofq_pkg::OP_PUSH, 64'h0123_4567_89ab_cdef, 1'b0, GOOD_LEN);
    send_beat(ofq_pkg::OP_POP, '0, 1'b0, GOOD_LEN);
    send_beat(ofq_pkg::OP_PUSH, 64'hfedc_ba98_7654_3210, 1'b0, '1);
    send_beat(ofq_pkg::OP_CLEAR, '0, 1'b0, '0);
    send_beat(ofq_pkg::OP_POP, '0, 1'b0, GOOD_LEN);
  endtask

  task automatic test_overflow_and_drop();
    holdoff_req = 1'b1;
    for (int f = 0; f < QUEUE_DEPTH + 1; f++) begin
      push_frame((f == 3) ? FR_NO_LAST : FR_CLEAN);
    end
    send_beat(ofq_pkg::OP_POP, '0, 1'b0, GOOD_LEN);
    send_beat(ofq_pkg::OP_POP, '0, 1'b0, bad_length());
    send_beat(ofq_pkg::OP_POP, '1, 1'b1, GOOD_LEN);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int r;
    int k;
    frame_kind_t kind;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        k = $urandom_range(0, 99);
        kind = (k < 64) ? FR_CLEAN : (k < 73) ? FR_NO_LAST : (k < 82) ? FR_EARLY_LAST :
               (k < 91) ? FR_WITH_POP : FR_WITH_CLEAR;
        push_frame(kind);
      end else if (r < 85) begin
        send_beat(ofq_pkg::OP_POP, frame_word(), rand_bit(),
                  ($urandom_range(0, 6) == 0) ? bad_length() : GOOD_LEN);
      end else if (r < 90) begin
        send_beat(ofq_pkg::OP_CLEAR, frame_word(), rand_bit(), LEN_W'($urandom));
      end else if (r < 95) begin
        send_beat(ofq_pkg::OP_PUSH, frame_word(), rand_bit(), bad_length());
      end else begin
        send_beat(ofq_pkg::OP_UNDEF, frame_word(), rand_bit(), LEN_W'($urandom));
      end
    end
  endtask

  task automatic test_drain();
    while (q_count != 0) send_beat(ofq_pkg::OP_POP, '0, 1'b0, GOOD_LEN);
    send_beat(ofq_pkg::OP_POP, '0, 1'b0, GOOD_LEN);
    send_beat(ofq_pkg::OP_CLEAR, '0, 1'b0, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = ofq_pkg::OP_PUSH;
    in_push_word = '0;
    in_push_last = 1'b0;
    in_frame_length = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_rejects_on_empty();
    test_overflow_and_drop();
    test_random_traffic();
    test_drain();
    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
